// ----- hdl/sc2a_pkg.sv -----
// Package for the scancode to ASCII FIFO unit: constants, decoder result
// struct and the character ROM function. No dependencies.
package sc2a_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SET_ADDR = 3'd0;

  localparam logic [1:0] SET_ONE   = 2'd1;
  localparam logic [1:0] SET_TWO   = 2'd2;
  localparam logic [1:0] SET_RESET = SET_ONE;

  localparam logic [7:0] BYTE_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] BYTE_REL_PREFIX = 8'hF0;
  localparam logic [7:0] EXT_ENTER_CODE  = 8'h1C;
  localparam logic [7:0] EXT_SLASH_CODE  = 8'h35;
  localparam logic [6:0] CHAR_NEWLINE    = 7'h0A;
  localparam logic [6:0] CHAR_SLASH      = 7'h2F;
  localparam logic [6:0] CHAR_NONE       = 7'h00;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic       push;
    logic [6:0] ch;
  } push_req_t;

  // Make code to ASCII; the two sets differ only in code 1 (ESC in set 1)
  function automatic logic [6:0] rom_char(input logic set_one, input logic [6:0] idx);
    logic [6:0] ch;
    case (idx)
      7'd1:  ch = set_one ? 7'h1B : 7'h00;
      7'd2:  ch = 7'h31;
      7'd3:  ch = 7'h32;
      7'd4:  ch = 7'h33;
      7'd5:  ch = 7'h34;
      7'd6:  ch = 7'h35;
      7'd7:  ch = 7'h36;
      7'd8:  ch = 7'h37;
      7'd9:  ch = 7'h38;
      7'd10: ch = 7'h39;
      7'd11: ch = 7'h30;
      7'd12: ch = 7'h2D;
      7'd13: ch = 7'h3D;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = 7'h71;
      7'd17: ch = 7'h77;
      7'd18: ch = 7'h65;
      7'd19: ch = 7'h72;
      7'd20: ch = 7'h74;
      7'd21: ch = 7'h79;
      7'd22: ch = 7'h75;
      7'd23: ch = 7'h69;
      7'd24: ch = 7'h6F;
      7'd25: ch = 7'h70;
      7'd26: ch = 7'h5B;
      7'd27: ch = 7'h5D;
      7'd28: ch = 7'h0A;
      7'd30: ch = 7'h61;
      7'd31: ch = 7'h73;
      7'd32: ch = 7'h64;
      7'd33: ch = 7'h66;
      7'd34: ch = 7'h67;
      7'd35: ch = 7'h68;
      7'd36: ch = 7'h6A;
      7'd37: ch = 7'h6B;
      7'd38: ch = 7'h6C;
      7'd39: ch = 7'h3B;
      7'd40: ch = 7'h27;
      7'd41: ch = 7'h60;
      7'd43: ch = 7'h5C;
      7'd44: ch = 7'h7A;
      7'd45: ch = 7'h78;
      7'd46: ch = 7'h63;
      7'd47: ch = 7'h76;
      7'd48: ch = 7'h62;
      7'd49: ch = 7'h6E;
      7'd50: ch = 7'h6D;
      7'd51: ch = 7'h2C;
      7'd52: ch = 7'h2E;
      7'd53: ch = 7'h2F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      7'd71: ch = 7'h37;
      7'd72: ch = 7'h38;
      7'd73: ch = 7'h39;
      7'd74: ch = 7'h2D;
      7'd75: ch = 7'h34;
      7'd76: ch = 7'h35;
      7'd77: ch = 7'h36;
      7'd78: ch = 7'h2B;
      7'd79: ch = 7'h31;
      7'd80: ch = 7'h32;
      7'd81: ch = 7'h33;
      7'd82: ch = 7'h30;
      7'd83: ch = 7'h2E;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/sc2a_decoder.sv -----
// Scancode byte decoder: extended/release prefix flags, break filtering and
// ROM lookup. Depends on sc2a_pkg.
module sc2a_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [1:0]          scancode_set,
  input  logic [7:0]          scan_byte,
  output sc2a_pkg::push_req_t req
);
  import sc2a_pkg::*;

  logic       ext_r, ext_nxt;
  logic       rel_r, rel_nxt;
  logic       set_one, set_two;
  logic [6:0] ch;

  assign set_one = (scancode_set == SET_ONE);
  assign set_two = (scancode_set == SET_TWO);

  always_comb begin
    ext_nxt  = ext_r;
    rel_nxt  = rel_r;
    req.push = 1'b0;
    ch       = CHAR_NONE;
    if (scan_byte == BYTE_EXT_PREFIX) begin
      ext_nxt = 1'b1;
    end else if (set_two && scan_byte == BYTE_REL_PREFIX) begin
      rel_nxt = 1'b1;
    end else begin
      ext_nxt = 1'b0;
      if (set_one && scan_byte[7]) begin
        // set 1 break code
      end else if (set_two && rel_r) begin
        rel_nxt = 1'b0;
      end else begin
        if (ext_r) begin
          if (scan_byte == EXT_ENTER_CODE) begin
            ch = CHAR_NEWLINE;
          end else if (scan_byte == EXT_SLASH_CODE) begin
            ch = CHAR_SLASH;
          end
        end else begin
          ch = rom_char(set_one, scan_byte[6:0]);
        end
        req.push = (ch != CHAR_NONE);
      end
    end
    req.push = req.push & take;
    req.ch   = ch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b0;
      rel_r <= 1'b0;
    end else if (take) begin
      ext_r <= ext_nxt;
      rel_r <= rel_nxt;
    end
  end

endmodule

// ----- hdl/scancode_to_ascii_fifo_unit.sv -----
// Top level: keyboard scancode decoder feeding a character FIFO held in a
// synchronous RAM, with an APB-style set register. Uses sc2a_pkg, sc2a_decoder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------
//  in       | in_valid / in_stall   | in_mode, in_scan_byte
//  out      | out_valid / out_stall | out_read_char, out_was_empty
//  cfg      | psel/penable/pwrite   | paddr, pwdata, prdata (pready=1)
//
// One input transaction per cycle while in_stall is low. A read's result is
// registered in the RAM read stage and then in the output register.
// Scancode bytes give no result and update the prefix flags and RAM write port.
// in_stall rises only when both the RAM read stage and the output register
// hold a read result while out_stall is high. Reset clears flags and pointers;
// the RAM itself is not cleared.
module scancode_to_ascii_fifo_unit #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [7:0]                      in_scan_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [6:0]                      out_read_char,
  output logic                            out_was_empty,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sc2a_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sc2a_pkg::DATA_W-1:0]     pwdata,
  output logic [sc2a_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import sc2a_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [1:0]       set_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_inc;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt, rd_inc;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_empty_r;
  logic [6:0]       rdata_r;
  logic             out_valid_r;
  logic [6:0]       out_char_r;
  logic             out_empty_r;
  logic             accept, take_byte, take_read, fifo_empty, fifo_full;
  logic             push, pop, s1_adv;
  push_req_t        req;
  logic [6:0]       mem [FIFO_DEPTH];

  // configuration register
  assign pready = 1'b1;
  assign prdata = {{(DATA_W-2){1'b0}}, set_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= SET_RESET;
    end else if (psel && penable && pwrite && paddr == REG_SET_ADDR) begin
      set_r <= pwdata[1:0];
    end
  end

  // handshake
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign take_byte = accept && in_mode == MODE_BYTE;
  assign take_read = accept && in_mode == MODE_READ;

  sc2a_decoder u_decoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take_byte),
    .scancode_set (set_r),
    .scan_byte    (in_scan_byte),
    .req          (req)
  );

  // ring pointers, wrap at any depth
  assign wr_inc     = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc     = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign fifo_empty = (wr_ptr_r == rd_ptr_r);
  assign fifo_full  = (wr_inc == rd_ptr_r);
  assign push       = req.push && !fifo_full;
  assign pop        = take_read && !fifo_empty;
  assign wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_inc : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // character RAM; a pop only reaches entries written at an earlier edge
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= req.ch;
    end
    if (pop) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  // read stage and output register
  always_comb begin
    if (take_read) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_read) begin
      s1_empty_r <= fifo_empty;
    end
    if (s1_adv) begin
      out_char_r  <= s1_empty_r ? CHAR_NONE : rdata_r;
      out_empty_r <= s1_empty_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_char = out_char_r;
  assign out_was_empty = out_empty_r;

  a_empty_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_char_r == CHAR_NONE)
    else $error("empty read returned a nonzero character");

  a_empty_read_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    take_read && fifo_empty |=> $stable(rd_ptr_r))
    else $error("read pointer moved on an empty read");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    req.push && fifo_full |=> $stable(wr_ptr_r))
    else $error("write pointer moved on a full FIFO");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= PTR_LAST && rd_ptr_r <= PTR_LAST)
    else $error("FIFO pointer out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("read stage lost a pending result");

endmodule
